// ===== rtl/ohr_pkg.sv =====
// ohr_pkg: shared types, widths, codes and the slot helper for the event history ring
// no dependencies; imported by the channel interfaces, ohr_ctrl and the ring unit
package ohr_pkg;

  // ring depth and derived widths
  localparam int MAX_ENTRIES = 32;
  localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int CODE_W    = 8;
  localparam int ENUM_W    = 4;
  localparam int WORD_W    = 32;
  localparam int IDX_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int TOTAL_W   = 6;
  localparam int CAP_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // common compare width for counts, indexes and capacity
  localparam int WIDE_A = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WIDE_B = (WIDE_A > IDX_W) ? WIDE_A : IDX_W;
  localparam int WIDE_W = WIDE_B + 1;

  localparam logic [WIDE_W-1:0] MAX_W = WIDE_W'(MAX_ENTRIES);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_LATEST = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_LIMIT = 2'd1;

  localparam logic [CODE_W-1:0] CODE_LIMIT_RESET = 8'd255;

  // one stored record
  typedef struct packed {
    logic [WORD_W-1:0] repeat_total;
    logic [WORD_W-1:0] time_ms;
    logic [ENUM_W-1:0] source;
    logic [ENUM_W-1:0] state;
    logic [ENUM_W-1:0] prio;
    logic [ENUM_W-1:0] category;
    logic [CODE_W-1:0] recovery;
    logic [CODE_W-1:0] code;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // controller to datapath: store access and result status
  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  total;
    logic                full;
  } ohr_req_t;

  // physical slot at an age from the oldest record, wrapped at the capacity
  function automatic logic [WIDE_W-1:0] slot_at(input logic [WIDE_W-1:0] base,
                                                input logic [WIDE_W-1:0] age,
                                                input logic [WIDE_W-1:0] cap);
    logic [WIDE_W-1:0] s;
    s = base + age;
    if (s >= cap) begin
      s = s - cap;
    end
    if (s >= MAX_W) begin
      s = '0;
    end
    return s;
  endfunction

endpackage

// ===== rtl/ohr_in_if.sv =====
// ohr_in_if: input item channel of the event history ring
// depends on ohr_pkg for field widths
interface ohr_in_if
  import ohr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CODE_W-1:0] alert_code;
  logic [CODE_W-1:0] recovery_code;
  logic [ENUM_W-1:0] alert_category;
  logic [ENUM_W-1:0] alert_priority;
  logic [ENUM_W-1:0] alert_state;
  logic [ENUM_W-1:0] alert_source;
  logic [WORD_W-1:0] time_ms;
  logic [WORD_W-1:0] repeat_total;
  logic [IDX_W-1:0]  read_index;

  modport source (
    output valid, op, alert_code, recovery_code, alert_category, alert_priority,
           alert_state, alert_source, time_ms, repeat_total, read_index,
    input  ready
  );

  modport sink (
    input  valid, op, alert_code, recovery_code, alert_category, alert_priority,
           alert_state, alert_source, time_ms, repeat_total, read_index,
    output ready
  );
endinterface

// ===== rtl/ohr_out_if.sv =====
// ohr_out_if: result channel of the event history ring
// depends on ohr_pkg for field widths
interface ohr_out_if
  import ohr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CODE_W-1:0]   out_code;
  logic [CODE_W-1:0]   out_recovery;
  logic [ENUM_W-1:0]   out_category;
  logic [ENUM_W-1:0]   out_priority;
  logic [ENUM_W-1:0]   out_state;
  logic [ENUM_W-1:0]   out_source;
  logic [WORD_W-1:0]   out_time_ms;
  logic [WORD_W-1:0]   out_repeat;
  logic [TOTAL_W-1:0]  stored_total;
  logic                is_full;

  modport source (
    output valid, status, out_code, out_recovery, out_category, out_priority,
           out_state, out_source, out_time_ms, out_repeat, stored_total, is_full,
    input  ready
  );

  modport sink (
    input  valid, status, out_code, out_recovery, out_category, out_priority,
           out_state, out_source, out_time_ms, out_repeat, stored_total, is_full,
    output ready
  );
endinterface

// ===== rtl/ohr_cfg_if.sv =====
// ohr_cfg_if: register write channel of the event history ring
// depends on ohr_pkg for index and data widths
interface ohr_cfg_if
  import ohr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ohr_ram.sv =====
// ohr_ram: generic single-write, single-read memory with registered read data
// no dependencies
module ohr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ohr_ctrl.sv =====
// ohr_ctrl: ring pointers, held count, config registers and per-item slot decode
// depends on ohr_pkg for types, codes and the slot helper
module ohr_ctrl
  import ohr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_fire,
  input  logic [OP_W-1:0]      item_op,
  input  logic [CODE_W-1:0]    item_code,
  input  logic [IDX_W-1:0]     item_index,
  input  logic                 cfg_fire,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output ohr_req_t             req
);

  logic [CAP_W-1:0]  capacity_r;
  logic [CODE_W-1:0] code_limit_r;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;

  logic [WIDE_W-1:0] cap_raw_w, cap_w, held_w, held_c, oldest_w, oldest_c;
  logic [WIDE_W-1:0] age_w, slot_w, next_oldest_w, held_after;
  logic              known, not_full;
  op_t               op;

  assign op = op_t'(item_op);

  // effective capacity and clamped pointers
  always_comb begin
    cap_raw_w = WIDE_W'(capacity_r);
    cap_w     = (cap_raw_w == '0 || cap_raw_w > MAX_W) ? MAX_W : cap_raw_w;
    held_w    = WIDE_W'(held_r);
    oldest_w  = WIDE_W'(oldest_r);
    held_c    = (held_w > cap_w) ? cap_w : held_w;
    oldest_c  = (oldest_w >= cap_w) ? '0 : oldest_w;
    known     = (item_code != '0) && (item_code <= code_limit_r);
    not_full  = held_c < cap_w;
  end

  // age of the slot this item touches
  always_comb begin
    unique case (op)
      OP_APPEND: age_w = not_full ? held_c : '0;
      OP_READ:   age_w = WIDE_W'(item_index);
      OP_LATEST: age_w = held_c - WIDE_W'(1);
      OP_CLEAR:  age_w = '0;
    endcase
  end

  assign slot_w        = slot_at(oldest_c, age_w, cap_w);
  assign next_oldest_w = slot_at(oldest_c, WIDE_W'(1), cap_w);

  // per-op decode: store access, status and next pointers
  always_comb begin
    req.wr_en  = 1'b0;
    req.rd_en  = 1'b0;
    req.slot   = SLOT_W'(slot_w);
    req.status = ST_OK;
    held_after = held_c;
    oldest_nxt = SLOT_W'(oldest_c);
    unique case (op)
      OP_APPEND: begin
        if (known) begin
          req.wr_en = 1'b1;
          if (not_full) begin
            held_after = held_c + WIDE_W'(1);
          end else begin
            oldest_nxt = SLOT_W'(next_oldest_w);
          end
        end else begin
          req.status = ST_REJECTED;
        end
      end
      OP_READ: begin
        if (WIDE_W'(item_index) < held_c) begin
          req.rd_en = 1'b1;
        end else begin
          req.status = ST_NOT_FOUND;
        end
      end
      OP_LATEST: begin
        if (held_c != '0) begin
          req.rd_en = 1'b1;
        end else begin
          req.status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        held_after = '0;
        oldest_nxt = '0;
      end
    endcase
    held_nxt  = CNT_W'(held_after);
    req.total = TOTAL_W'(held_after);
    req.full  = held_after == cap_w;
  end

  // ring state and registers; a capacity write empties the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= '0;
      code_limit_r <= CODE_LIMIT_RESET;
      held_r       <= '0;
      oldest_r     <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_CAPACITY: begin
          capacity_r <= cfg_data[CAP_W-1:0];
          held_r     <= '0;
          oldest_r   <= '0;
        end
        REG_CODE_LIMIT: code_limit_r <= cfg_data;
        default: ;
      endcase
    end else if (item_fire) begin
      held_r   <= held_nxt;
      oldest_r <= oldest_nxt;
    end
  end

endmodule

// ===== rtl/overwriting_event_history_ring_unit.sv =====
// overwriting_event_history_ring_unit: alert history ring that overwrites the oldest record
// a result is offered in the cycle after its input transfer
// throughput: one item per cycle while the result drains, set by the single store access per item
// the result register parts the channels; input is taken while the result drains
// reset: empty ring, capacity maximum, code limit 255; store contents undefined until written
// depends on ohr_pkg, the channel interfaces, ohr_ctrl and ohr_ram
module overwriting_event_history_ring_unit
  import ohr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  ohr_in_if.sink   in_ch,
  ohr_out_if.source out_ch,
  ohr_cfg_if.sink  cfg_ch
);

  ohr_req_t            req;
  rec_t                wr_rec, rd_rec, shown_rec;
  logic [REC_W-1:0]    rd_data;
  logic                in_fire;
  logic                res_valid_r;
  logic                rec_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [TOTAL_W-1:0]  total_r;
  logic                full_r;

  // input transfer whenever the result register is empty or draining
  assign in_ch.ready  = !res_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  ohr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (in_fire),
    .item_op    (in_ch.op),
    .item_code  (in_ch.alert_code),
    .item_index (in_ch.read_index),
    .cfg_fire   (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .req        (req)
  );

  // record to store
  always_comb begin
    wr_rec.code         = in_ch.alert_code;
    wr_rec.recovery     = in_ch.recovery_code;
    wr_rec.category     = in_ch.alert_category;
    wr_rec.prio         = in_ch.alert_priority;
    wr_rec.state        = in_ch.alert_state;
    wr_rec.source       = in_ch.alert_source;
    wr_rec.time_ms      = in_ch.time_ms;
    wr_rec.repeat_total = in_ch.repeat_total;
  end

  ohr_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && req.wr_en),
    .waddr (req.slot),
    .wdata (wr_rec),
    .re    (in_fire && req.rd_en),
    .raddr (req.slot),
    .rdata (rd_data)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_fire) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  // result status fields, captured with the store read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rec_valid_r <= req.rd_en;
      status_r    <= req.status;
      total_r     <= req.total;
      full_r      <= req.full;
    end
  end

  // record fields read as zero when no record was read
  assign rd_rec    = rec_t'(rd_data);
  assign shown_rec = rec_valid_r ? rd_rec : '0;

  assign out_ch.valid        = res_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.out_code     = shown_rec.code;
  assign out_ch.out_recovery = shown_rec.recovery;
  assign out_ch.out_category = shown_rec.category;
  assign out_ch.out_priority = shown_rec.prio;
  assign out_ch.out_state    = shown_rec.state;
  assign out_ch.out_source   = shown_rec.source;
  assign out_ch.out_time_ms  = shown_rec.time_ms;
  assign out_ch.out_repeat   = shown_rec.repeat_total;
  assign out_ch.stored_total = total_r;
  assign out_ch.is_full      = full_r;

endmodule
